@@ rtl/core/frustum_cull_test_core_assert.svh @@
// Assertion macros used by the frustum test core controller.
`ifndef FRUSTUM_CULL_TEST_CORE_ASSERT_SVH
`define FRUSTUM_CULL_TEST_CORE_ASSERT_SVH

// Checked on every clock edge outside reset; expects clk and rst_n in scope.
`define FCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included; expects clk in scope.
`define FCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/fct_pkg.sv @@
// Package with the shared constants, types and codes of the frustum test core.
`default_nettype none
package fct_pkg;

  // Geometry and fixed point format.
  localparam int NUM_PLANES    = 6;
  localparam int FRACTION_BITS = 16;

  // Field and datapath widths.
  localparam int CW     = 32;
  localparam int PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int PW     = 2 * CW;
  localparam int OEW    = CW + FRACTION_BITS + 1;
  localparam int SW     = PW + 1;
  localparam int TW     = PW + 2;

  // Stream widths.
  localparam int IN_TDATA_W  = 232;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_POINT  = 2'd1,
    ACT_SPHERE = 2'd2,
    ACT_BOX    = 2'd3
  } fct_action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              accept;
    logic              issue;
    logic [PIDX_W-1:0] plane;
    logic              publish;
  } fct_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;
  } fct_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/fct_ctrl.sv @@
// Controller state machine: item acceptance, plane sequencing and result hand-off.
`default_nettype none
`include "frustum_cull_test_core_assert.svh"
module fct_ctrl
  import fct_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TUSER_W-1:0] in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire fct_sts_t              sts,
  output fct_cmd_t                   cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  localparam logic [PIDX_W-1:0] LAST_PLANE = PIDX_W'(NUM_PLANES - 1);

  state_t            state_r, state_nxt;
  logic [PIDX_W-1:0] cnt_r, cnt_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic              acc;
  logic              slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign acc        = in_tvalid && in_tready;
  assign slot_free  = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd.accept  = acc;
    cmd.issue   = 1'b0;
    cmd.plane   = cnt_r;
    cmd.publish = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (acc && (fct_action_t'(in_tuser) != ACT_LOAD)) begin
          state_nxt = S_ISSUE;
          cnt_nxt   = '0;
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (cnt_r == LAST_PLANE) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + PIDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (!sts.busy && slot_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set by a publish, cleared when the item is taken.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.publish) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  `FCT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE) && !out_tvalid_r, "reset did not return the controller to idle")
  `FCT_ASSERT(a_test_starts, (acc && (fct_action_t'(in_tuser) != ACT_LOAD)) |=> (state_r == S_ISSUE) && (cnt_r == '0), "test item did not start plane issue")
  `FCT_ASSERT(a_issue_ends, (state_r == S_ISSUE) && (cnt_r == LAST_PLANE) |=> (state_r == S_DRAIN), "plane issue did not stop after the last plane")
  `FCT_ASSERT(a_publish_free, cmd.publish |-> !sts.busy && slot_free, "result published over a pending item or a busy pipeline")

endmodule
`default_nettype wire

@@ rtl/core/fct_dpath.sv @@
// Datapath: plane store, operand capture, shared multipliers and distance sign check.
`default_nettype none
module fct_dpath
  import fct_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  input  wire fct_cmd_t               cmd,
  output fct_sts_t                    sts,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  // Input field unpacking.
  logic        [2:0]    f_index;
  logic signed [CW-1:0] f_fx, f_fy, f_fz, f_sx, f_sy, f_sz, f_sc;
  fct_action_t          f_act;

  assign f_act   = fct_action_t'(in_tuser);
  assign f_index = in_tdata[2:0];
  assign f_fx    = in_tdata[34:3];
  assign f_fy    = in_tdata[66:35];
  assign f_fz    = in_tdata[98:67];
  assign f_sx    = in_tdata[130:99];
  assign f_sy    = in_tdata[162:131];
  assign f_sz    = in_tdata[194:163];
  assign f_sc    = in_tdata[226:195];

  // Plane store, cleared by reset and written by load items.
  logic signed [CW-1:0] nx_mem_r  [NUM_PLANES];
  logic signed [CW-1:0] ny_mem_r  [NUM_PLANES];
  logic signed [CW-1:0] nz_mem_r  [NUM_PLANES];
  logic signed [CW-1:0] off_mem_r [NUM_PLANES];
  logic                 wr_en;
  logic [PIDX_W-1:0]    wr_idx;

  assign wr_en  = cmd.accept && (f_act == ACT_LOAD) && ({29'd0, f_index} < NUM_PLANES);
  assign wr_idx = PIDX_W'(f_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_PLANES; k++) begin
        nx_mem_r[k]  <= '0;
        ny_mem_r[k]  <= '0;
        nz_mem_r[k]  <= '0;
        off_mem_r[k] <= '0;
      end
    end else if (wr_en) begin
      nx_mem_r[wr_idx]  <= f_fx;
      ny_mem_r[wr_idx]  <= f_fy;
      nz_mem_r[wr_idx]  <= f_fz;
      off_mem_r[wr_idx] <= f_sc;
    end
  end

  // Operands of the test item in progress.
  fct_action_t          act_r;
  logic signed [CW-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r, sc_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && (f_act != ACT_LOAD)) begin
      act_r <= f_act;
      ax_r  <= f_fx;
      ay_r  <= f_fy;
      az_r  <= f_fz;
      bx_r  <= f_sx;
      by_r  <= f_sy;
      bz_r  <= f_sz;
      sc_r  <= f_sc;
    end
  end

  // Stage A: read one plane and pick the coordinate for each axis.
  // For a box, the positive vertex takes the larger coordinate where the
  // normal component is non-negative and the smaller one where it is negative.
  logic signed [CW-1:0] rd_nx, rd_ny, rd_nz, rd_off;
  logic signed [CW-1:0] sel_x_nxt, sel_y_nxt, sel_z_nxt, ext_nxt;

  assign rd_nx  = nx_mem_r[cmd.plane];
  assign rd_ny  = ny_mem_r[cmd.plane];
  assign rd_nz  = nz_mem_r[cmd.plane];
  assign rd_off = off_mem_r[cmd.plane];

  always_comb begin
    sel_x_nxt = ax_r;
    sel_y_nxt = ay_r;
    sel_z_nxt = az_r;
    ext_nxt   = '0;
    case (act_r)
      ACT_SPHERE: begin
        ext_nxt = sc_r;
      end
      ACT_BOX: begin
        sel_x_nxt = ((bx_r > ax_r) != rd_nx[CW-1]) ? bx_r : ax_r;
        sel_y_nxt = ((by_r > ay_r) != rd_ny[CW-1]) ? by_r : ay_r;
        sel_z_nxt = ((bz_r > az_r) != rd_nz[CW-1]) ? bz_r : az_r;
      end
      default: begin
        ext_nxt = '0;
      end
    endcase
  end

  logic                 va_r, vb_r, vc_r;
  logic signed [CW-1:0] mnx_r, mny_r, mnz_r, mcx_r, mcy_r, mcz_r, off_r, ext_r;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      mnx_r <= rd_nx;
      mny_r <= rd_ny;
      mnz_r <= rd_nz;
      mcx_r <= sel_x_nxt;
      mcy_r <= sel_y_nxt;
      mcz_r <= sel_z_nxt;
      off_r <= rd_off;
      ext_r <= ext_nxt;
    end
  end

  // Stage B: three shared multipliers and the scaled offset plus radius.
  logic signed [PW-1:0]  px_r, py_r, pz_r;
  logic signed [OEW-1:0] oe_r;

  always_ff @(posedge clk) begin
    px_r <= PW'(mnx_r) * PW'(mcx_r);
    py_r <= PW'(mny_r) * PW'(mcy_r);
    pz_r <= PW'(mnz_r) * PW'(mcz_r);
    oe_r <= (OEW'(off_r) <<< FRACTION_BITS) + (OEW'(ext_r) <<< FRACTION_BITS);
  end

  // Stage C: two partial sums.
  logic signed [SW-1:0] s1_r, s2_r;

  always_ff @(posedge clk) begin
    s1_r <= SW'(px_r) + SW'(py_r);
    s2_r <= SW'(pz_r) + SW'(oe_r);
  end

  // Stage D: full distance and its sign, folded into the visibility flag.
  logic signed [TW-1:0] total;
  logic                 pass;
  logic                 vis_r;
  logic                 res_r;

  assign total = TW'(s1_r) + TW'(s2_r);
  assign pass  = !total[TW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      vc_r  <= 1'b0;
      vis_r <= 1'b1;
    end else begin
      va_r <= cmd.issue;
      vb_r <= va_r;
      vc_r <= vb_r;
      if (cmd.accept && (f_act != ACT_LOAD)) begin
        vis_r <= 1'b1;
      end else if (vc_r) begin
        vis_r <= vis_r & pass;
      end
    end
  end

  // Result register, loaded when the controller publishes.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      res_r <= vis_r;
    end
  end

  assign sts.busy  = va_r || vb_r || vc_r;
  assign out_tdata = {{(OUT_TDATA_W - 1){1'b0}}, res_r};

endmodule
`default_nettype wire

@@ rtl/core/frustum_cull_test_core.sv @@
// Top level of the six-plane view frustum visibility test core.
//
//  Channel | Direction | Payload
//  in_     | input     | tuser: action; tdata: plane index, first xyz, second xyz, scalar
//  out_    | output    | tdata: visible flag in bit 0
//
// A load item gives no result.
// A test item is accepted and its NUM_PLANES planes are issued in turn to the three shared
// multipliers, which evaluate one plane per cycle, then pass through pipeline stages B to D.
// The result is published, and the input readied, when pipeline and output slot are free.
// No input item is taken while a test runs; one is taken while a result waits.
// Reset clears the plane store to zero and empties the output.
`default_nettype none
module frustum_cull_test_core
  import fct_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // Fields from bit 0: plane_index[2:0], first_x, first_y, first_z, second_x,
  // second_y, second_z, scalar (32 bits each), zero padding.
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: action[1:0].
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // Fields from bit 0: visible[0], zero padding.
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  fct_cmd_t cmd;
  fct_sts_t sts;

  fct_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  fct_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule
`default_nettype wire
